FILE: hdl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and helper functions for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int LEN_BITS   = 64;   // message byte counter width (32..64)
  localparam int ROUNDS     = 64;
  localparam int BLK_WORDS  = 16;

  typedef logic [31:0]                word_t;
  typedef logic [7:0][31:0]           cv_t;
  typedef logic [BLK_WORDS-1:0][31:0] win_t;
  typedef logic [LEN_BITS-1:0]        count_t;

  typedef struct packed {
    logic  push;    // shift a message word into the window
    word_t word;
    logic  start;   // load working registers and begin 64 rounds
  } cmp_ctl_t;

  localparam cv_t SM3_IV = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  localparam word_t T_LOW   = 32'h79cc4519;
  localparam word_t T_HIGH  = 32'h7a879d8a;
  localparam word_t PAD_MARK = 32'h80000000;

  function automatic word_t rotl(word_t x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic word_t perm0(word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // round constant already rotated by j mod 32
  function automatic word_t t_rot(logic [5:0] j);
    word_t t;
    t = (j < 6'd16) ? T_LOW : T_HIGH;
    return rotl(t, j[4:0]);
  endfunction

endpackage

FILE: hdl/sm3_compress.sv
// ----------------------------------------------------------------------------
// sm3_compress
// One SM3 round per cycle over a sliding 16-word message window; the
// message expansion shifts a new word into the window each round.
// ----------------------------------------------------------------------------
module sm3_compress (
  input  logic             clk,
  input  logic             rst,
  input  sm3_pkg::cmp_ctl_t ctl,
  input  sm3_pkg::cv_t     cv_in,
  output logic             done,
  output sm3_pkg::cv_t     work_next
);
  import sm3_pkg::*;

  logic       busy;
  logic [5:0] round;
  win_t       win;
  cv_t        work;
  word_t      w_new;

  word_t a12, ss1, ss2, tt1, tt2, ff, gg, wj, wpj;
  logic  early;

  always_comb begin
    early = (round < 6'd16);
    wj    = win[0];
    wpj   = win[0] ^ win[4];
    a12   = rotl(work[0], 5'd12);
    ss1   = rotl(a12 + work[4] + t_rot(round), 5'd7);
    ss2   = ss1 ^ a12;
    if (early) begin
      ff = work[0] ^ work[1] ^ work[2];
      gg = work[4] ^ work[5] ^ work[6];
    end else begin
      ff = (work[0] & work[1]) | (work[0] & work[2]) | (work[1] & work[2]);
      gg = (work[4] & work[5]) | (~work[4] & work[6]);
    end
    tt1 = ff + work[3] + ss2 + wpj;
    tt2 = gg + work[7] + ss1 + wj;
    work_next[3] = work[2];
    work_next[2] = rotl(work[1], 5'd9);
    work_next[1] = work[0];
    work_next[0] = tt1;
    work_next[7] = work[6];
    work_next[6] = rotl(work[5], 5'd19);
    work_next[5] = work[4];
    work_next[4] = perm0(tt2);
    // W[j+16] from the window holding W[j..j+15]
    w_new = perm1(win[0] ^ win[7] ^ rotl(win[13], 5'd15))
            ^ rotl(win[3], 5'd7) ^ win[10];
  end

  assign done = busy && (round == 6'(ROUNDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= '0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      round <= '0;
    end else if (busy) begin
      round <= round + 6'd1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      win <= {ctl.word, win[15:1]};
    end else if (busy) begin
      win <= {w_new, win[15:1]};
    end
    if (ctl.start) begin
      work <= cv_in;
    end else if (busy) begin
      work <= work_next;
    end
  end

endmodule

FILE: hdl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// sm3_hash_engine
// Streaming SM3 hash: message words in, eight 32-bit digest words out.
// ----------------------------------------------------------------------------
// Input channel (message_valid/message_ready): big-endian 32-bit words, first
// byte in bits 31:24. message_last marks the final word; valid_bytes gives its
// count of leading valid bytes (0..4, larger values count as 4).
// Output channel (digest_valid/digest_ready): eight transactions per message,
// digest_index 0..7, digest_last on the eighth.
// Words that do not complete a 16-word block are accepted back to back. A word
// that completes a block starts 64 rounds in the shared round unit, one round
// per cycle, during which no input is taken. After the last word the engine
// pushes one padding word per cycle while not compressing, and compresses once
// or twice more, then presents the digest.
// The engine takes no input while compressing, padding or emitting.
// Reset loads the IV, clears the byte count and block fill, and leaves the
// engine idle. A stalled receiver holds the current digest word stable; the
// engine waits and accepts the next message only after the eighth word.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        message_valid,
  output logic        message_ready,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        message_last,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_last
);
  import sm3_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_COMP = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    PH_MARK  = 4'b0001,
    PH_ZERO  = 4'b0010,
    PH_LENLO = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  state_t   state, state_next;
  phase_t   phase, phase_next;
  logic     padding, padding_next;
  logic [3:0] fill;
  count_t   count, count_next;
  cv_t      cv;
  logic [2:0] out_idx;

  cmp_ctl_t ctl;
  logic     cmp_done;
  cv_t      work_next;

  logic        accept, out_accept;
  logic [2:0]  vb_sat;
  word_t       merged;
  logic [63:0] bit_len;

  assign message_ready = (state == ST_IDLE);
  assign accept        = message_valid && message_ready;
  assign digest_valid  = (state == ST_OUT);
  assign out_accept    = digest_valid && digest_ready;
  assign digest_word   = cv[out_idx];
  assign digest_index  = out_idx;
  assign digest_last   = (out_idx == 3'd7);

  assign vb_sat  = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
  assign bit_len = 64'(count) << 3;

  always_comb begin
    unique case (vb_sat)
      3'd1:    merged = {message_word[31:24], 24'h800000};
      3'd2:    merged = {message_word[31:16], 16'h8000};
      3'd3:    merged = {message_word[31:8], 8'h80};
      default: merged = PAD_MARK;   // no valid bytes: marker starts a fresh word
    endcase
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    padding_next = padding;
    count_next   = count;
    ctl.push     = 1'b0;
    ctl.word     = '0;
    ctl.start    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.push = 1'b1;
          if (!message_last) begin
            ctl.word   = message_word;
            count_next = count + count_t'(3'd4);
          end else begin
            count_next   = count + count_t'(vb_sat);
            padding_next = 1'b1;
            state_next   = ST_PAD;
            if (vb_sat == 3'd4) begin
              ctl.word   = message_word;
              phase_next = PH_MARK;
            end else begin
              ctl.word   = merged;
              phase_next = PH_ZERO;
            end
          end
        end
      end
      ST_PAD: begin
        ctl.push = 1'b1;
        unique case (phase)
          PH_MARK: begin
            ctl.word   = PAD_MARK;
            phase_next = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill == 4'd14) begin
              ctl.word   = bit_len[63:32];
              phase_next = PH_LENLO;
            end else begin
              ctl.word = '0;
            end
          end
          PH_LENLO: begin
            ctl.word   = bit_len[31:0];
            phase_next = PH_DONE;
          end
          default: begin
            ctl.word = '0;
          end
        endcase
      end
      ST_COMP: begin
        if (cmp_done) begin
          if (!padding) begin
            state_next = ST_IDLE;
          end else if (phase == PH_DONE) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (out_accept && digest_last) begin
          state_next   = ST_IDLE;
          padding_next = 1'b0;
          count_next   = '0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // 16th word of a block kicks off a compression
    if (ctl.push && fill == 4'd15) begin
      ctl.start  = 1'b1;
      state_next = ST_COMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= PH_DONE;
      padding <= 1'b0;
      fill    <= '0;
      count   <= '0;
      out_idx <= '0;
      cv      <= SM3_IV;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      padding <= padding_next;
      count   <= count_next;
      if (ctl.push) begin
        fill <= fill + 4'd1;
      end
      if (cmp_done) begin
        for (int k = 0; k < 8; k++) begin
          cv[k] <= cv[k] ^ work_next[k];
        end
      end else if (out_accept && digest_last) begin
        cv <= SM3_IV;
      end
      if (out_accept) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  sm3_compress u_compress (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cv_in     (cv),
    .done      (cmp_done),
    .work_next (work_next)
  );

endmodule
